FILE: sv/page_framebuffer_draw_engine_defines.svh
// assertion macros shared by the checker files of the draw engine
// depends on nothing; included by name where assertions are written
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define PFDE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define PFDE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pfde_pkg.sv
// package of the page framebuffer draw engine: geometry, codes, states, font rom
// depends on nothing; used by the top level and the checker
package pfde_pkg;

  localparam int COLUMNS  = 128;
  localparam int PAGES    = 8;

  localparam int GLYPH_W  = 6;
  localparam int FIRST_CODE = 32;
  localparam int LAST_CODE  = 127;
  localparam int MAX_WORDS  = 16;

  localparam int COL_W    = $clog2(COLUMNS);
  localparam int CX_W     = $clog2(COLUMNS + 1);
  localparam int PX_W     = $clog2(PAGES + 1);
  localparam int ADDR_W   = $clog2(PAGES) + COL_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam int RD_WORDS = ((COLUMNS + 7) / 8 > MAX_WORDS) ? MAX_WORDS : (COLUMNS + 7) / 8;
  localparam int RD_COLS  = RD_WORDS * 8;
  localparam int RCOL_W   = 7;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'd0,
    MODE_PIXEL = 3'd1,
    MODE_GLYPH = 3'd2,
    MODE_FILL  = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_GLYPH,
    ST_FILL,
    ST_READ,
    ST_READ_END
  } state_t;

  // store address: page in the upper bits, column in the lower COL_W bits
  function automatic logic [ADDR_W-1:0] mk_addr(input logic [8:0] page, input logic [8:0] col);
    logic [ADDR_W+8:0] t;
    t = ((ADDR_W + 9)'(page) << COL_W) | (ADDR_W + 9)'(col);
    return t[ADDR_W-1:0];
  endfunction

  // 6x8 font for codes 32..127, leftmost column in the top byte
  localparam logic [47:0] GLYPH_ROM [96] = '{
    48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
    48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
    48'h001C22410000, 48'h0041221C0000, 48'h082A1C2A0800, 48'h08083E080800,
    48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
    48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
    48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
    48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
    48'h000814224100, 48'h141414141400, 48'h412214080000, 48'h020151090600,
    48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
    48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909010100, 48'h3E4141513200,
    48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
    48'h7F4040404000, 48'h7F0204027F00, 48'h7F0408107F00, 48'h3E4141413E00,
    48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
    48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h7F2018207F00,
    48'h631408146300, 48'h030478040300, 48'h615149454300, 48'h00007F414100,
    48'h020408102000, 48'h41417F000000, 48'h040201020400, 48'h404040404000,
    48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
    48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h081454543C00,
    48'h7F0804047800, 48'h00447D400000, 48'h2040443D0000, 48'h007F10284400,
    48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
    48'h7C1414140800, 48'h081414187C00, 48'h7C0804040800, 48'h485454542000,
    48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
    48'h442810284400, 48'h0C5050503C00, 48'h4464544C4400, 48'h000836410000,
    48'h00007F000000, 48'h004136080000, 48'h08082A1C0800, 48'h000000000000
  };

endpackage

FILE: sv/page_framebuffer_draw_engine.sv
// page framebuffer draw engine: frame store in a ram, sequencer for draw and read commands
// depends on pfde_pkg and pfde_ram
//
//   channel   handshake            payload
//   command   start / busy         in_mode in_x_pos in_y_pos in_pixel_on in_char_code
//                                  in_fill_width in_fill_height in_fill_byte
//   result    out_valid (strobe)   out_page_word out_word_index out_last_word
//
// one command at a time; busy is high while a command works
// work per command: clear writes every ram cell, pixel writes back the byte read at acceptance,
//   glyph writes up to 6 columns, fill writes width*height cells after clipping, page read reads RD_COLS columns
// commands that draw nothing leave the engine idle, and busy does not rise
// reset starts a clearing pass over the whole ram with busy high
// results are strobed for one cycle, one word per eight columns read; the receiver cannot stall
module page_framebuffer_draw_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_x_pos,
  input  logic [7:0]  in_y_pos,
  input  logic        in_pixel_on,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_fill_width,
  input  logic [7:0]  in_fill_height,
  input  logic [7:0]  in_fill_byte,
  output logic        out_valid,
  output logic [63:0] out_page_word,
  output logic [3:0]  out_word_index,
  output logic        out_last_word
);

  localparam int AW = pfde_pkg::ADDR_W;
  localparam int CW = pfde_pkg::CX_W;
  localparam int PW = pfde_pkg::PX_W;
  localparam int RW = pfde_pkg::RCOL_W;

  pfde_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]    mask_r, mask_nxt;
  logic          on_r, on_nxt;
  logic [47:0]   glyph_r, glyph_nxt;
  logic [2:0]    gcnt_r, gcnt_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] x_start_r, x_start_nxt;
  logic [CW-1:0] x_end_r, x_end_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [PW-1:0] p_end_r, p_end_nxt;
  logic [7:0]    fill_r, fill_nxt;
  logic [RW-1:0] rcol_r, rcol_nxt;

  logic          rd_vld_r, rd_vld_nxt;
  logic [RW-1:0] rd_col_r, rd_col_nxt;
  logic          rd_in_r, rd_in_nxt;
  logic [63:0]   acc_r, acc_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_word_r, out_word_nxt;
  logic [3:0]    out_idx_r, out_idx_nxt;
  logic          out_last_r, out_last_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [6:0]    glyph_idx;
  logic [8:0]    x_sum, y_sum, x_end_c, p_end_c;
  logic [7:0]    rd_byte;

  pfde_ram #(
    .WIDTH (8),
    .DEPTH (pfde_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command decode helpers
  always_comb begin
    if (in_char_code inside {[pfde_pkg::FIRST_CODE:pfde_pkg::LAST_CODE]}) begin
      glyph_idx = 7'(in_char_code - 8'(pfde_pkg::FIRST_CODE));
    end else begin
      glyph_idx = '0;
    end
    x_sum   = 9'(in_x_pos) + 9'(in_fill_width);
    y_sum   = 9'(in_y_pos) + 9'(in_fill_height);
    x_end_c = (x_sum > 9'(pfde_pkg::COLUMNS)) ? 9'(pfde_pkg::COLUMNS) : x_sum;
    p_end_c = (y_sum > 9'(pfde_pkg::PAGES)) ? 9'(pfde_pkg::PAGES) : y_sum;
  end

  assign rd_byte = rd_in_r ? ram_rdata : 8'h00;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    addr_nxt     = addr_r;
    mask_nxt     = mask_r;
    on_nxt       = on_r;
    glyph_nxt    = glyph_r;
    gcnt_nxt     = gcnt_r;
    col_nxt      = col_r;
    x_start_nxt  = x_start_r;
    x_end_nxt    = x_end_r;
    page_nxt     = page_r;
    p_end_nxt    = p_end_r;
    fill_nxt     = fill_r;
    rcol_nxt     = rcol_r;

    rd_vld_nxt   = 1'b0;
    rd_col_nxt   = rd_col_r;
    rd_in_nxt    = rd_in_r;

    ram_we       = 1'b0;
    ram_waddr    = addr_r;
    ram_wdata    = 8'h00;
    ram_raddr    = pfde_pkg::mk_addr(9'(in_y_pos[7:3]), 9'(in_x_pos));

    case (state_r)
      pfde_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = 8'h00;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = pfde_pkg::ST_IDLE;
        end
      end
      pfde_pkg::ST_IDLE: begin
        if (start) begin
          case (in_mode)
            pfde_pkg::MODE_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = pfde_pkg::ST_CLEAR;
            end
            pfde_pkg::MODE_PIXEL: begin
              // the ram read of this cell is issued now, written back next cycle
              if (9'(in_x_pos) < 9'(pfde_pkg::COLUMNS) &&
                  9'(in_y_pos) < 9'(pfde_pkg::PAGES * 8)) begin
                addr_nxt  = pfde_pkg::mk_addr(9'(in_y_pos[7:3]), 9'(in_x_pos));
                mask_nxt  = 8'b1 << in_y_pos[2:0];
                on_nxt    = in_pixel_on;
                state_nxt = pfde_pkg::ST_PIX_WR;
              end
            end
            pfde_pkg::MODE_GLYPH: begin
              if (9'(in_x_pos) < 9'(pfde_pkg::COLUMNS) &&
                  9'(in_y_pos) < 9'(pfde_pkg::PAGES)) begin
                glyph_nxt = pfde_pkg::GLYPH_ROM[glyph_idx];
                gcnt_nxt  = '0;
                col_nxt   = CW'(in_x_pos);
                page_nxt  = PW'(in_y_pos);
                state_nxt = pfde_pkg::ST_GLYPH;
              end
            end
            pfde_pkg::MODE_FILL: begin
              if (9'(in_x_pos) < x_end_c && 9'(in_y_pos) < p_end_c) begin
                col_nxt     = CW'(in_x_pos);
                x_start_nxt = CW'(in_x_pos);
                x_end_nxt   = CW'(x_end_c);
                page_nxt    = PW'(in_y_pos);
                p_end_nxt   = PW'(p_end_c);
                fill_nxt    = in_fill_byte;
                state_nxt   = pfde_pkg::ST_FILL;
              end
            end
            pfde_pkg::MODE_READ: begin
              if (9'(in_y_pos) < 9'(pfde_pkg::PAGES)) begin
                page_nxt  = PW'(in_y_pos);
                rcol_nxt  = '0;
                state_nxt = pfde_pkg::ST_READ;
              end
            end
            default: begin
              state_nxt = pfde_pkg::ST_IDLE;
            end
          endcase
        end
      end
      pfde_pkg::ST_PIX_WR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = on_r ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
        state_nxt = pfde_pkg::ST_IDLE;
      end
      pfde_pkg::ST_GLYPH: begin
        // column stays in range: the walk stops at the right edge
        ram_we    = 1'b1;
        ram_waddr = pfde_pkg::mk_addr(9'(page_r), 9'(col_r));
        ram_wdata = glyph_r[47:40];
        glyph_nxt = glyph_r << 8;
        gcnt_nxt  = gcnt_r + 1'b1;
        col_nxt   = col_r + 1'b1;
        if (gcnt_r == 3'(pfde_pkg::GLYPH_W - 1) || col_r == CW'(pfde_pkg::COLUMNS - 1)) begin
          state_nxt = pfde_pkg::ST_IDLE;
        end
      end
      pfde_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = pfde_pkg::mk_addr(9'(page_r), 9'(col_r));
        ram_wdata = fill_r;
        if (col_r + 1'b1 == x_end_r) begin
          col_nxt  = x_start_r;
          page_nxt = page_r + 1'b1;
          if (page_r + 1'b1 == p_end_r) begin
            state_nxt = pfde_pkg::ST_IDLE;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      pfde_pkg::ST_READ: begin
        ram_raddr  = pfde_pkg::mk_addr(9'(page_r), 9'(rcol_r));
        rd_vld_nxt = 1'b1;
        rd_col_nxt = rcol_r;
        rd_in_nxt  = 9'(rcol_r) < 9'(pfde_pkg::COLUMNS);
        rcol_nxt   = rcol_r + 1'b1;
        if (rcol_r == RW'(pfde_pkg::RD_COLS - 1)) begin
          state_nxt = pfde_pkg::ST_READ_END;
        end
      end
      pfde_pkg::ST_READ_END: begin
        // last byte lands this cycle, its word is strobed next cycle
        state_nxt = pfde_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pfde_pkg::ST_IDLE;
      end
    endcase
  end

  // word assembly from the registered ram data
  always_comb begin
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    if (rd_vld_r) begin
      acc_nxt[{rd_col_r[2:0], 3'b000} +: 8] = rd_byte;
      if (rd_col_r[2:0] == 3'd7) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = {rd_byte, acc_r[55:0]};
        out_idx_nxt   = rd_col_r[6:3];
        out_last_nxt  = rd_col_r == RW'(pfde_pkg::RD_COLS - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfde_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    on_r       <= on_nxt;
    glyph_r    <= glyph_nxt;
    gcnt_r     <= gcnt_nxt;
    col_r      <= col_nxt;
    x_start_r  <= x_start_nxt;
    x_end_r    <= x_end_nxt;
    page_r     <= page_nxt;
    p_end_r    <= p_end_nxt;
    fill_r     <= fill_nxt;
    rcol_r     <= rcol_nxt;
    rd_col_r   <= rd_col_nxt;
    rd_in_r    <= rd_in_nxt;
    acc_r      <= acc_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy           = state_r != pfde_pkg::ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_page_word  = out_word_r;
  assign out_word_index = out_idx_r;
  assign out_last_word  = out_last_r;

endmodule

FILE: sv/pfde_ram.sv
// generic single-port-write, single-port-read ram with a registered read
// depends on nothing
module pfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/pfde_checker.sv
// port-level checks of the draw engine's page read results, bound to the top level
// depends on pfde_pkg and page_framebuffer_draw_engine_defines.svh
`include "page_framebuffer_draw_engine_defines.svh"

module pfde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic [3:0] out_word_index,
  input logic       out_last_word
);

  // a word only comes out of a command that was still at work
  `PFDE_ASSERT_IMP(a_word_after_busy, clk, rst_n, out_valid, $past(busy), "word without a running read")

  // a word that is not the last of its page is followed by the next word of that page
  `PFDE_ASSERT_IMP(a_word_spacing, clk, rst_n, out_valid && !out_last_word, ##8 out_valid, "page read word missing")

  // the final word carries the last index of the page
  `PFDE_ASSERT_IMP(a_last_index, clk, rst_n, out_valid && out_last_word, out_word_index == 4'(pfde_pkg::RD_WORDS - 1), "last word has wrong index")

  // a read is still in progress while it has words left
  `PFDE_ASSERT_IMP(a_busy_mid_read, clk, rst_n, out_valid && !out_last_word, busy, "engine idle in the middle of a read")

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_word_index (out_word_index),
  .out_last_word  (out_last_word)
);
